// ===== design/rpt_pkg.sv =====
`timescale 1ns / 1ps
package rpt_pkg;
    localparam int PIXEL_BITS   = 12;
    localparam int FRAC_BITS    = 4;
    localparam int CORDIC_STEPS = 16;
    localparam int POS_W  = PIXEL_BITS + FRAC_BITS;
    localparam int VEC_W  = POS_W + 1;
    localparam int GUARD  = 8;
    localparam int CX_W   = VEC_W + GUARD + 3;
    localparam int Z_W    = 24;
    localparam int MAG_W  = 17;
    localparam int ANG_W  = 15;
    localparam int INV_GAIN = 39797;
    localparam int ANG_LIMIT = 180 * 64;
    localparam int HALF_TURN_Z = 180 * 16384;
    localparam int NUM_REGS = 5;
    localparam int ADDR_W = 5;

    typedef enum logic [2:0] {
        REG_FRAME_W = 3'd0, REG_FRAME_H = 3'd1, REG_SIDE = 3'd2,
        REG_SOFF_X = 3'd3, REG_SOFF_Y = 3'd4
    } t_reg_idx;

    typedef struct packed {
        logic              valid;
        logic signed [CX_W-1:0] x;
        logic signed [CX_W-1:0] y;
        logic signed [Z_W-1:0]  z;
        logic              zero;
    } t_cordic_data;

    function automatic logic signed [Z_W-1:0] atan_lut(input logic [4:0] i);
        logic signed [Z_W-1:0] r;
        unique case (i)
            5'd0: r = 24'sd737280;  5'd1: r = 24'sd435242;
            5'd2: r = 24'sd229970;  5'd3: r = 24'sd116736;
            5'd4: r = 24'sd58595;   5'd5: r = 24'sd29326;
            5'd6: r = 24'sd14667;   5'd7: r = 24'sd7334;
            5'd8: r = 24'sd3667;    5'd9: r = 24'sd1833;
            5'd10: r = 24'sd917;    5'd11: r = 24'sd458;
            5'd12: r = 24'sd229;    5'd13: r = 24'sd115;
            5'd14: r = 24'sd57;     5'd15: r = 24'sd29;
            5'd16: r = 24'sd14;     5'd17: r = 24'sd7;
            5'd18: r = 24'sd4;      5'd19: r = 24'sd2;
            5'd20: r = 24'sd1;
            default: r = '0;
        endcase
        return r;
    endfunction
endpackage

// ===== design/rpt_if.sv =====
`timescale 1ns / 1ps
interface rpt_in_if;
    logic valid;
    logic ready;
    logic found;
    logic [15:0] centre_x;
    logic [15:0] centre_y;
    modport source (output valid, found, centre_x, centre_y, input ready);
    modport sink   (input valid, found, centre_x, centre_y, output ready);
endinterface

interface rpt_out_if;
    logic valid;
    logic ready;
    logic [15:0] pos_x;
    logic [15:0] pos_y;
    logic signed [16:0] vel_x;
    logic signed [16:0] vel_y;
    logic [16:0] speed;
    logic signed [14:0] heading;
    logic signed [16:0] rel_x;
    logic signed [16:0] rel_y;
    logic [16:0] rel_dist;
    logic signed [14:0] rel_angle;
    logic [11:0] window_x;
    logic [11:0] window_y;
    modport source (output valid, pos_x, pos_y, vel_x, vel_y, speed, heading, rel_x, rel_y,
                    rel_dist, rel_angle, window_x, window_y, input ready);
    modport sink   (input valid, pos_x, pos_y, vel_x, vel_y, speed, heading, rel_x, rel_y,
                    rel_dist, rel_angle, window_x, window_y, output ready);
endinterface

// ===== design/rpt_cordic_cell.sv =====
`timescale 1ns / 1ps
module rpt_cordic_cell (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic [4:0]            i_step,
    input  rpt_pkg::t_cordic_data i_data,
    output rpt_pkg::t_cordic_data o_data
);
    import rpt_pkg::*;
    t_cordic_data r_data;
    t_cordic_data n_data;
    logic signed [CX_W-1:0] w_dx, w_dy;

    always_comb begin
        w_dx = i_data.y >>> i_step;
        w_dy = i_data.x >>> i_step;
        n_data = i_data;
        if (i_data.y >= 0) begin
            n_data.x = i_data.x + w_dx;
            n_data.y = i_data.y - w_dy;
            n_data.z = i_data.z + atan_lut(i_step);
        end else begin
            n_data.x = i_data.x - w_dx;
            n_data.y = i_data.y + w_dy;
            n_data.z = i_data.z - atan_lut(i_step);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_data.valid <= 1'b0;
        end else begin
            r_data.valid <= i_data.valid;
        end
        r_data.x <= n_data.x;
        r_data.y <= n_data.y;
        r_data.z <= n_data.z;
        r_data.zero <= n_data.zero;
    end
    assign o_data = r_data;
endmodule

// ===== design/rpt_cordic_chain.sv =====
`timescale 1ns / 1ps
module rpt_cordic_chain (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic signed [rpt_pkg::VEC_W-1:0] i_x,
    input  logic signed [rpt_pkg::VEC_W-1:0] i_y,
    output logic                          o_done,
    output logic [rpt_pkg::MAG_W-1:0]     o_mag,
    output logic signed [rpt_pkg::ANG_W-1:0] o_ang
);
    import rpt_pkg::*;
    t_cordic_data w_link [0:CORDIC_STEPS];
    t_cordic_data r_out;
    logic signed [CX_W-1:0] w_xe, w_ye;
    logic signed [CX_W+17:0] w_prod;
    logic signed [CX_W+17:0] w_m;
    logic signed [Z_W-1:0] w_a;

    always_comb begin
        w_xe = CX_W'(i_x) <<< GUARD;
        w_ye = CX_W'(i_y) <<< GUARD;
        w_link[0].valid = i_start;
        w_link[0].zero = (i_x == 0) && (i_y == 0);
        w_link[0].z = '0;
        if (i_x < 0) begin
            w_link[0].x = -w_xe;
            w_link[0].y = -w_ye;
            w_link[0].z = (i_y >= 0) ? Z_W'(HALF_TURN_Z) : -Z_W'(HALF_TURN_Z);
        end else begin
            w_link[0].x = w_xe;
            w_link[0].y = w_ye;
        end
    end

    for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_cell
        rpt_cordic_cell u_cell (
            .i_clk(i_clk), .i_rst_n(i_rst_n), .i_step(5'(g)),
            .i_data(w_link[g]), .o_data(w_link[g+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out.valid <= 1'b0;
        end else begin
            r_out.valid <= w_link[CORDIC_STEPS].valid;
        end
        r_out.x <= w_link[CORDIC_STEPS].x;
        r_out.y <= w_link[CORDIC_STEPS].y;
        r_out.z <= w_link[CORDIC_STEPS].z;
        r_out.zero <= w_link[CORDIC_STEPS].zero;
    end

    always_comb begin
        w_prod = (CX_W+18)'(r_out.x) * (CX_W+18)'(INV_GAIN);
        w_m = (w_prod + ((CX_W+18)'(1) <<< (15 + GUARD))) >>> (16 + GUARD);
        w_a = (r_out.z + Z_W'(128)) >>> 8;
        if (r_out.zero) begin
            o_mag = '0;
            o_ang = '0;
        end else begin
            if (w_m < 0) o_mag = '0;
            else if (w_m > 131071) o_mag = '1;
            else o_mag = MAG_W'(w_m);
            if (w_a > ANG_LIMIT) o_ang = ANG_W'(ANG_LIMIT);
            else if (w_a < -ANG_LIMIT) o_ang = -ANG_W'(ANG_LIMIT);
            else o_ang = ANG_W'(w_a);
        end
    end
    assign o_done = r_out.valid;
endmodule

// ===== design/roi_position_tracker.sv =====
`timescale 1ns / 1ps
// ROI position tracker.
// An item enters on the in channel (found flag and a centroid inside the tracking
// window, 12.4 fixed point) and one result item leaves on the out channel with the
// absolute position, velocity, speed and heading, the offset, distance and angle
// from the frame centre, and the updated window origin.
// Registers are written over the APB port: frame width, frame height, window
// side and the two search offsets, at byte addresses 0, 4, 8, 12 and 16.
// One item is worked on at a time. The item is captured on acceptance, the position and
// window are updated from it, then both vectors run side by side down a chain of
// CORDIC_STEPS cells plus one output register, and the result is registered.
// The next item is taken in the cycle after the result is taken, so a new item is
// never taken before the last result has left, and none while the receiver holds off.
// A stalled result simply holds on the out channel until ready is seen.
// Reset clears the last position and window origin to zero and loads the
// register reset values.
module roi_position_tracker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    rpt_in_if.sink      in_ch,
    rpt_out_if.source   out_ch,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [rpt_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import rpt_pkg::*;

    typedef enum logic [1:0] {S_IDLE, S_CALC, S_WAIT, S_OUT} t_state;
    t_state r_state;

    logic [11:0] r_fw, r_fh, r_side, r_sox, r_soy;
    logic [POS_W-1:0] r_last_x, r_last_y;
    logic [11:0] r_org_x, r_org_y;
    logic r_found;
    logic [15:0] r_cx, r_cy;
    logic signed [VEC_W-1:0] r_vx, r_vy, r_rx, r_ry;
    logic r_start;

    logic [2:0] w_idx;
    assign w_idx = paddr[4:2];
    assign pready = 1'b1;

    always_comb begin
        unique case (w_idx)
            REG_FRAME_W: prdata = {20'd0, r_fw};
            REG_FRAME_H: prdata = {20'd0, r_fh};
            REG_SIDE:    prdata = {20'd0, r_side};
            REG_SOFF_X:  prdata = {20'd0, r_sox};
            REG_SOFF_Y:  prdata = {20'd0, r_soy};
            default:     prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fw <= 12'd640; r_fh <= 12'd480; r_side <= 12'd96;
            r_sox <= '0; r_soy <= '0;
        end else if (psel && penable && pwrite) begin
            unique case (w_idx)
                REG_FRAME_W: r_fw <= pwdata[11:0];
                REG_FRAME_H: r_fh <= pwdata[11:0];
                REG_SIDE:    r_side <= pwdata[11:0];
                REG_SOFF_X:  r_sox <= pwdata[11:0];
                REG_SOFF_Y:  r_soy <= pwdata[11:0];
                default: ;
            endcase
        end
    end

    // Position and window follow logic, evaluated from the captured item.
    logic [POS_W:0] w_px_s, w_py_s;
    logic [POS_W-1:0] w_px, w_py;
    assign w_px_s = (POS_W+1)'(r_cx) + ((POS_W+1)'(r_org_x) << FRAC_BITS);
    assign w_py_s = (POS_W+1)'(r_cy) + ((POS_W+1)'(r_org_y) << FRAC_BITS);
    assign w_px = w_px_s[POS_W] ? '1 : w_px_s[POS_W-1:0];
    assign w_py = w_py_s[POS_W] ? '1 : w_py_s[POS_W-1:0];

    function automatic logic [11:0] follow(input logic [11:0] org, input logic [POS_W-1:0] pos,
                                           input logic [11:0] size, input logic [11:0] side);
        logic [10:0] half;
        logic [POS_W:0] half_f;
        logic signed [13:0] o;
        half = side[11:1];
        half_f = (POS_W+1)'(half) << FRAC_BITS;
        o = 14'(org);
        if ((POS_W+1)'(pos) > half_f)
            o = 14'(pos >> FRAC_BITS) - 14'(half);
        if ((POS_W+1)'(pos) + half_f >= ((POS_W+1)'(size) << FRAC_BITS))
            o = 14'(size) - 14'(side);
        if (o < 0) o = '0;
        return o[11:0];
    endfunction

    logic w_done;
    logic [MAG_W-1:0] w_spd, w_rd;
    logic signed [ANG_W-1:0] w_hdg, w_ra;
    logic w_rel_done;

    assign in_ch.ready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_last_x <= '0; r_last_y <= '0;
            r_org_x <= '0; r_org_y <= '0;
            r_start <= 1'b0;
            out_ch.valid <= 1'b0;
        end else begin
            r_start <= (r_state == S_CALC);
            unique case (r_state)
                S_IDLE: begin
                    if (in_ch.valid) begin
                        r_found <= in_ch.found;
                        r_cx <= in_ch.centre_x;
                        r_cy <= in_ch.centre_y;
                        r_state <= S_CALC;
                    end
                end
                S_CALC: begin
                    if (r_found) begin
                        r_vx <= VEC_W'(w_px) - VEC_W'(r_last_x);
                        r_vy <= VEC_W'(w_py) - VEC_W'(r_last_y);
                        r_last_x <= w_px;
                        r_last_y <= w_py;
                        r_rx <= VEC_W'(w_px) - (VEC_W'(r_fw[11:1]) << FRAC_BITS);
                        r_ry <= VEC_W'(w_py) - (VEC_W'(r_fh[11:1]) << FRAC_BITS);
                        r_org_x <= follow(r_org_x, w_px, r_fw, r_side);
                        r_org_y <= follow(r_org_y, w_py, r_fh, r_side);
                    end else begin
                        r_vx <= '0;
                        r_vy <= '0;
                        r_rx <= VEC_W'(r_last_x) - (VEC_W'(r_fw[11:1]) << FRAC_BITS);
                        r_ry <= VEC_W'(r_last_y) - (VEC_W'(r_fh[11:1]) << FRAC_BITS);
                        r_org_x <= r_sox;
                        r_org_y <= r_soy;
                    end
                    r_state <= S_WAIT;
                end
                S_WAIT: begin
                    if (w_done && w_rel_done) begin
                        out_ch.pos_x <= r_last_x;
                        out_ch.pos_y <= r_last_y;
                        out_ch.vel_x <= r_vx;
                        out_ch.vel_y <= r_vy;
                        out_ch.speed <= w_spd;
                        out_ch.heading <= w_hdg;
                        out_ch.rel_x <= r_rx;
                        out_ch.rel_y <= r_ry;
                        out_ch.rel_dist <= w_rd;
                        out_ch.rel_angle <= w_ra;
                        out_ch.window_x <= r_org_x;
                        out_ch.window_y <= r_org_y;
                        out_ch.valid <= 1'b1;
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (out_ch.ready) begin
                        out_ch.valid <= 1'b0;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Velocity chain: a zero vector gives zero speed and heading, so a lost item
    // produces zero motion outputs naturally.
    rpt_cordic_chain u_vel (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(r_start),
        .i_x(r_vx), .i_y(r_vy), .o_done(w_done), .o_mag(w_spd), .o_ang(w_hdg)
    );

    rpt_cordic_chain u_rel (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(r_start),
        .i_x(r_rx), .i_y(r_ry), .o_done(w_rel_done), .o_mag(w_rd), .o_ang(w_ra)
    );
endmodule

// ===== design/rpt_checker.sv =====
`timescale 1ns / 1ps
module rpt_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready,
    input logic [11:0] window_x
);
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !out_ready |=> out_valid) else $error("result dropped");
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid |-> !in_ready) else $error("input taken while result pending");
    a_accept_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_valid && in_ready |=> !out_valid) else $error("result too early");
    a_win_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !out_ready |=> $stable(window_x)) else $error("window changed");
endmodule

bind roi_position_tracker rpt_checker u_rpt_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .window_x(out_ch.window_x)
);

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
module testbench;
    import rpt_pkg::*;

    // Clock, reset and the APB configuration port.
    logic i_clk;
    logic i_rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic pready;

    rpt_in_if  in_ch ();
    rpt_out_if out_ch ();

    roi_position_tracker DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .in_ch   (in_ch),
        .out_ch  (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // One expected result item, laid out as the out channel carries it.
    typedef struct {
        logic [15:0]        pos_x;
        logic [15:0]        pos_y;
        logic signed [16:0] vel_x;
        logic signed [16:0] vel_y;
        logic [16:0]        speed;
        logic signed [14:0] heading;
        logic signed [16:0] rel_x;
        logic signed [16:0] rel_y;
        logic [16:0]        rel_dist;
        logic signed [14:0] rel_angle;
        logic [11:0]        window_x;
        logic [11:0]        window_y;
    } track_result_t;

    track_result_t track_expected_q[$];

    // The predictor's own copy of the registers and the tracking state.
    longint reg_val[NUM_REGS];
    longint trk_last_x;
    longint trk_last_y;
    longint trk_org_x;
    longint trk_org_y;

    // Idling controls, in percent per cycle, changed from phase to phase.
    int send_idle_pct;
    int recv_stall_pct;

    int mismatches;
    int unexpected;

    // Arc tangents of 2^-i in 1/16384 degree, the same constants as the design's
    // CORDIC uses; the predictor keeps a copy of its own.
    localparam longint ATAN_STEP[16] = '{
        737280, 435242, 229970, 116736, 58595, 29326, 14667, 7334,
        3667, 1833, 917, 458, 229, 115, 57, 29
    };

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // A generous ceiling on the whole run; a hang ends here as a failure.
    initial begin
        #4000000;
        $display("testbench: errors");
        $finish;
    end

    // Vectoring CORDIC: magnitude in 12.4 and angle in 1/64 degree of (x, y).
    // The vector is first folded into the right half plane, scaled by the guard
    // bits, rotated toward the x axis, and finally scaled by the inverse gain.
    function automatic void polar_of(input longint vx, input longint vy,
                                     output longint mag, output longint ang);
        longint x;
        longint y;
        longint z;
        longint dx;
        longint dy;
        x = vx;
        y = vy;
        z = 0;
        if (x == 0 && y == 0) begin
            mag = 0;
            ang = 0;
            return;
        end
        if (x < 0) begin
            z = (y >= 0) ? longint'(HALF_TURN_Z) : -longint'(HALF_TURN_Z);
            x = -x;
            y = -y;
        end
        x = x * 256;
        y = y * 256;
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y >= 0) begin
                x = x + dx;
                y = y - dy;
                z = z + ATAN_STEP[i];
            end else begin
                x = x - dx;
                y = y + dy;
                z = z - ATAN_STEP[i];
            end
        end
        mag = (x * INV_GAIN + (longint'(1) << 23)) >>> 24;
        ang = (z + 128) >>> 8;
        if (mag < 0) mag = 0;
        if (mag > 131071) mag = 131071;
        if (ang > ANG_LIMIT) ang = ANG_LIMIT;
        if (ang < -ANG_LIMIT) ang = -ANG_LIMIT;
    endfunction

    // Window origin update along one axis: recentre past half the side, then
    // clamp at the far edge, then keep within the pixel range.
    function automatic longint window_follow(input longint org, input longint pos,
                                             input longint size, input longint side);
        longint half;
        longint r;
        half = side / 2;
        r = org;
        if (pos > half * 16) r = (pos >>> FRAC_BITS) - half;
        if (pos + half * 16 >= size * 16) r = size - side;
        if (r < 0) r = 0;
        if (r > 4095) r = 4095;
        return r;
    endfunction

    // Works out the result of one accepted item and advances the predicted state.
    function automatic track_result_t track_predict(input logic found,
                                                    input logic [15:0] cx,
                                                    input logic [15:0] cy);
        track_result_t r;
        longint px;
        longint py;
        longint vx;
        longint vy;
        longint spd;
        longint hdg;
        longint rx;
        longint ry;
        longint rd;
        longint ra;
        vx = 0;
        vy = 0;
        spd = 0;
        hdg = 0;
        if (found) begin
            px = longint'(cx) + trk_org_x * 16;
            py = longint'(cy) + trk_org_y * 16;
            if (px > 65535) px = 65535;
            if (py > 65535) py = 65535;
            vx = px - trk_last_x;
            vy = py - trk_last_y;
            polar_of(vx, vy, spd, hdg);
            trk_last_x = px;
            trk_last_y = py;
            trk_org_x = window_follow(trk_org_x, px, reg_val[REG_FRAME_W], reg_val[REG_SIDE]);
            trk_org_y = window_follow(trk_org_y, py, reg_val[REG_FRAME_H], reg_val[REG_SIDE]);
        end else begin
            // Target lost: the window goes back to the search offsets.
            trk_org_x = reg_val[REG_SOFF_X];
            trk_org_y = reg_val[REG_SOFF_Y];
        end
        rx = trk_last_x - (reg_val[REG_FRAME_W] / 2) * 16;
        ry = trk_last_y - (reg_val[REG_FRAME_H] / 2) * 16;
        polar_of(rx, ry, rd, ra);
        r.pos_x     = trk_last_x[15:0];
        r.pos_y     = trk_last_y[15:0];
        r.vel_x     = vx[16:0];
        r.vel_y     = vy[16:0];
        r.speed     = spd[16:0];
        r.heading   = hdg[14:0];
        r.rel_x     = rx[16:0];
        r.rel_y     = ry[16:0];
        r.rel_dist  = rd[16:0];
        r.rel_angle = ra[14:0];
        r.window_x  = trk_org_x[11:0];
        r.window_y  = trk_org_y[11:0];
        return r;
    endfunction

    task automatic compare_field(input string name, input longint exp_v, input longint act_v);
        if (exp_v != act_v) begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch %s: expected %0d, got %0d", name, exp_v, act_v);
        end
    endtask

    // Receiver side: ready changes on the falling edge, stalling at random.
    initial begin
        out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            out_ch.ready = ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Every result item taken at a rising edge is checked against the oldest
    // expectation.
    always @(posedge i_clk) begin
        track_result_t e;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (track_expected_q.size() == 0) begin
                unexpected++;
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: result item with nothing expected");
            end else begin
                e = track_expected_q.pop_front();
                compare_field("pos_x", e.pos_x, out_ch.pos_x);
                compare_field("pos_y", e.pos_y, out_ch.pos_y);
                compare_field("vel_x", e.vel_x, out_ch.vel_x);
                compare_field("vel_y", e.vel_y, out_ch.vel_y);
                compare_field("speed", e.speed, out_ch.speed);
                compare_field("heading", e.heading, out_ch.heading);
                compare_field("rel_x", e.rel_x, out_ch.rel_x);
                compare_field("rel_y", e.rel_y, out_ch.rel_y);
                compare_field("rel_dist", e.rel_dist, out_ch.rel_dist);
                compare_field("rel_angle", e.rel_angle, out_ch.rel_angle);
                compare_field("window_x", e.window_x, out_ch.window_x);
                compare_field("window_y", e.window_y, out_ch.window_y);
            end
        end
    end

    // Sends one item. Called just after a rising edge; inputs change at the
    // falling edge. Valid stays high into the next call so that back-to-back
    // items need no gap.
    task automatic send_frame(input logic found, input logic [15:0] cx, input logic [15:0] cy);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid = 1'b0;
            in_ch.found = $urandom_range(1);
            @(negedge i_clk);
        end
        in_ch.valid    = 1'b1;
        in_ch.found    = found;
        in_ch.centre_x = cx;
        in_ch.centre_y = cy;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        track_expected_q = {track_expected_q, track_predict(found, cx, cy)};
    endtask

    // Lowers valid and waits until every expected result has come, plus the
    // pipeline depth so that the block is idle.
    task automatic drain_results();
        @(negedge i_clk);
        in_ch.valid = 1'b0;
        while (track_expected_q.size() != 0) @(posedge i_clk);
        repeat (CORDIC_STEPS + 10) @(posedge i_clk);
    endtask

    // APB write: a setup cycle, then an access cycle that lands on a rising edge.
    task automatic write_reg(input t_reg_idx idx, input logic [11:0] value);
        @(negedge i_clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = ADDR_W'(4 * int'(idx));
        pwdata  = {20'd0, value};
        @(negedge i_clk);
        penable = 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        reg_val[idx] = value;
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_geometry(input logic [11:0] fw, input logic [11:0] fh,
                                input logic [11:0] side,
                                input logic [11:0] sx, input logic [11:0] sy);
        write_reg(REG_FRAME_W, fw);
        write_reg(REG_FRAME_H, fh);
        write_reg(REG_SIDE, side);
        write_reg(REG_SOFF_X, sx);
        write_reg(REG_SOFF_Y, sy);
    endtask

    // Directed frames at the reset geometry: centroid extremes, saturation,
    // a repeated position (zero velocity), motion straight along the negative
    // x axis, a position exactly at the frame centre, and lost frames.
    task automatic test_directed_frames();
        send_frame(1'b1, 16'd0, 16'd0);
        send_frame(1'b1, 16'd0, 16'd0);
        send_frame(1'b1, 16'hFFFF, 16'hFFFF);
        send_frame(1'b1, 16'hFFFF, 16'h0000);
        send_frame(1'b0, 16'hFFFF, 16'hFFFF);
        send_frame(1'b1, 16'd800, 16'd640);
        send_frame(1'b1, 16'd400, 16'd640);
        send_frame(1'b0, 16'd0, 16'd0);
        // From a zero origin, land exactly on the frame centre.
        send_frame(1'b1, 16'd5120, 16'd3840);
        send_frame(1'b0, 16'd0, 16'd0);
        send_frame(1'b1, 16'd3000, 16'd3000);
        send_frame(1'b1, 16'd1000, 16'd3000);
        send_frame(1'b1, 16'd1000, 16'd5000);
        send_frame(1'b1, 16'hAAAA, 16'h5555);
        send_frame(1'b1, 16'h5555, 16'hAAAA);
        drain_results();
    endtask

    // Register extremes: smallest and largest frame and window, search offsets
    // at the top, and a window larger than the frame so the edge clamp goes
    // negative.
    task automatic test_register_extremes();
        set_geometry(12'd1, 12'd1, 12'd2, 12'd4095, 12'd4095);
        send_frame(1'b0, 16'd0, 16'd0);
        send_frame(1'b1, 16'd16, 16'd0);
        send_frame(1'b1, 16'd0, 16'hFFFF);
        send_frame(1'b0, 16'd0, 16'd0);
        drain_results();
        set_geometry(12'd4095, 12'd4095, 12'd4095, 12'd0, 12'd4095);
        send_frame(1'b1, 16'hFFFF, 16'd123);
        send_frame(1'b1, 16'd32768, 16'd32768);
        send_frame(1'b0, 16'd0, 16'd0);
        send_frame(1'b1, 16'd0, 16'd0);
        drain_results();
        set_geometry(12'd100, 12'd50, 12'd200, 12'd4095, 12'd0);
        send_frame(1'b1, 16'd1600, 16'd800);
        send_frame(1'b1, 16'd400, 16'd100);
        drain_results();
    endtask

    // Random frames. Most follow a target that wanders inside the window, so
    // the origin really tracks; some are lost frames and some use the full
    // centroid range.
    task automatic test_random_track(input int n_frames, input int idle_pct, input int stall_pct);
        int kind;
        int span;
        logic [15:0] cx;
        logic [15:0] cy;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        for (int n = 0; n < n_frames; n++) begin
            kind = $urandom_range(99);
            span = int'(reg_val[REG_SIDE]) * 16;
            if (kind < 10) begin
                send_frame(1'b0, 16'($urandom), 16'($urandom));
            end else if (kind < 25) begin
                send_frame(1'b1, 16'($urandom), 16'($urandom));
            end else begin
                cx = 16'($urandom_range(span));
                cy = 16'($urandom_range(span));
                send_frame(1'b1, cx, cy);
            end
        end
        drain_results();
    endtask

    task automatic test_random_geometry();
        set_geometry(12'($urandom_range(4095, 64)), 12'($urandom_range(4095, 64)),
                     12'($urandom_range(256, 2)), 12'($urandom), 12'($urandom));
        test_random_track(100, 18, 18);
        set_geometry(12'd640, 12'd480, 12'd96, 12'd0, 12'd0);
    endtask

    initial begin
        i_rst_n        = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        in_ch.valid    = 1'b0;
        in_ch.found    = 1'b0;
        in_ch.centre_x = '0;
        in_ch.centre_y = '0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        mismatches     = 0;
        unexpected     = 0;
        reg_val[REG_FRAME_W] = 640;
        reg_val[REG_FRAME_H] = 480;
        reg_val[REG_SIDE]    = 96;
        reg_val[REG_SOFF_X]  = 0;
        reg_val[REG_SOFF_Y]  = 0;
        trk_last_x = 0;
        trk_last_y = 0;
        trk_org_x  = 0;
        trk_org_y  = 0;
        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(posedge i_clk);

        test_directed_frames();
        test_register_extremes();
        set_geometry(12'd640, 12'd480, 12'd96, 12'd20, 12'd30);
        test_random_track(150, 0, 0);
        test_random_track(150, 57, 0);
        test_random_track(150, 0, 57);
        test_random_track(150, 18, 18);
        test_random_geometry();

        if (mismatches == 0 && track_expected_q.size() == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end
endmodule
